FILE: src/bpfa_pkg.sv
package bpfa_pkg;

  localparam int WORD_W        = 64;
  localparam int BIT_W         = 6;
  localparam int PAGE_W        = 12;
  localparam int CNT_OUT_W     = 13;
  localparam int PAGES_DEFAULT = 4096;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RESERVE = 2'd1,
    FUNC_FREE    = 2'd2
  } func_e;

  // index of the lowest set bit; x must not be zero
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] iso;
    logic [BIT_W-1:0]  idx;
    iso = x & (~x + WORD_W'(1));
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (iso[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: src/bpfa_if.sv
interface bpfa_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [bpfa_pkg::PAGE_W-1:0]    page_index;

  modport source (output valid, func, page_index, input ready);
  modport sink   (input valid, func, page_index, output ready);
endinterface

interface bpfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bpfa_pkg::PAGE_W-1:0]    allocated_page;
  logic                           found;
  logic [bpfa_pkg::CNT_OUT_W-1:0] free_pages;
  logic [bpfa_pkg::CNT_OUT_W-1:0] used_pages;
  logic [bpfa_pkg::CNT_OUT_W-1:0] reserved_pages;

  modport source (output valid, allocated_page, found, free_pages, used_pages,
                  reserved_pages, input ready);
  modport sink   (input valid, allocated_page, found, free_pages, used_pages,
                  reserved_pages, output ready);
endinterface

FILE: src/bpfa_map.sv
module bpfa_map #(
  parameter int WORDS  = bpfa_pkg::PAGES_DEFAULT / bpfa_pkg::WORD_W,
  parameter int ADDR_W = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  output logic [bpfa_pkg::WORD_W-1:0]   rd_data_o,
  input  logic                          wr_en_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  logic [bpfa_pkg::WORD_W-1:0]   wr_data_i,
  output logic                          busy_o
);

  logic [bpfa_pkg::WORD_W-1:0] mem [WORDS];
  logic [ADDR_W-1:0]           clr_q, clr_d;
  logic                        busy_q, busy_d;

  // sweep after reset: page 0 reserved, all else free
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + ADDR_W'(1);
      if (clr_q == ADDR_W'(WORDS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= (clr_q == '0) ? bpfa_pkg::WORD_W'(1) : '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign busy_o = busy_q;

endmodule

FILE: src/bitmap_page_frame_allocator_top.sv
// Page frame allocator over a bitmap held in one single-port-read memory of
// 64-bit words. A request is registered with its map word read; in the check
// state the result goes to the output register, waiting while that register
// still holds an untaken result. An allocate reads one more word for every
// full word it steps over past the search pointer, which marks the lowest word
// that may still hold a clear bit; the map is updated by a read-modify-write,
// one word read per cycle. After reset a clearing pass writes the map's
// (PAGES+63)/64 words (64 at the default size) one word a cycle, with ready
// held low. One request is worked on at a time; a finished result sits in the
// output register while the next request is taken.
module bitmap_page_frame_allocator_top #(
  parameter int PAGES = bpfa_pkg::PAGES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpfa_req_if.sink   req_i,
  bpfa_rsp_if.source rsp_o
);

  localparam int WW      = bpfa_pkg::WORD_W;
  localparam int BW      = bpfa_pkg::BIT_W;
  localparam int WORDS   = (PAGES + WW - 1) / WW;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W   = (WADDR_W + BW > bpfa_pkg::PAGE_W) ? WADDR_W + BW
                                                             : bpfa_pkg::PAGE_W;
  localparam int CNT_W   = $clog2(PAGES + 1);
  localparam int CX_W    = (CNT_W > bpfa_pkg::CNT_OUT_W) ? CNT_W : bpfa_pkg::CNT_OUT_W;
  localparam int LAST_BITS = PAGES - (WORDS - 1) * WW;
  localparam logic [WW-1:0] PAD_MASK =
    (LAST_BITS >= WW) ? '0 : ~((WW'(1) << LAST_BITS) - WW'(1));

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CHK  = 1'b1;

  logic               state_q, state_d;
  logic [1:0]         func_q, func_d;
  logic [WADDR_W-1:0] word_q, word_d;
  logic [BW-1:0]      bit_q, bit_d;
  logic               pvalid_q, pvalid_d;
  logic [WADDR_W-1:0] hint_q, hint_d;
  logic [CNT_W-1:0]   free_q, free_d, used_q, used_d, rsv_q, rsv_d;

  logic                          out_valid_q, out_valid_d;
  logic [bpfa_pkg::PAGE_W-1:0]   out_page_q, out_page_d;
  logic                          out_found_q, out_found_d;
  logic [bpfa_pkg::CNT_OUT_W-1:0] out_free_q, out_used_q, out_rsv_q;

  logic               rd_en, wr_en, busy;
  logic [WADDR_W-1:0] rd_addr, wr_addr;
  logic [WW-1:0]      rd_data, wr_data, masked;
  logic [BW-1:0]      lo;
  logic               accept, out_free, finish;
  logic [IDX_W-1:0]   idx_in, idx_got;
  logic [CX_W-1:0]    free_x, used_x, rsv_x;

  bpfa_map #(.WORDS(WORDS), .ADDR_W(WADDR_W)) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .busy_o    (busy)
  );

  assign req_i.ready = (state_q == ST_IDLE) && !busy;
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign idx_in      = IDX_W'(req_i.page_index);
  assign masked      = rd_data | ((hint_q == WADDR_W'(WORDS - 1)) ? PAD_MASK : '0);
  assign lo          = bpfa_pkg::lowest_one(~masked);
  assign idx_got     = IDX_W'({hint_q, lo});

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    word_d      = word_q;
    bit_d       = bit_q;
    pvalid_d    = pvalid_q;
    hint_d      = hint_q;
    free_d      = free_q;
    used_d      = used_q;
    rsv_d       = rsv_q;
    out_page_d  = '0;
    out_found_d = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = hint_q;
    wr_en       = 1'b0;
    wr_addr     = hint_q;
    wr_data     = rd_data;
    finish      = 1'b0;

    if (state_q == ST_IDLE) begin
      if (accept) begin
        func_d   = req_i.func;
        pvalid_d = 32'(req_i.page_index) < PAGES;
        word_d   = pvalid_d ? idx_in[BW +: WADDR_W] : '0;
        bit_d    = req_i.page_index[BW-1:0];
        rd_en    = 1'b1;
        rd_addr  = (req_i.func == bpfa_pkg::FUNC_ALLOC) ? hint_q : word_d;
        state_d  = ST_CHK;
      end
    end else begin
      case (bpfa_pkg::func_e'(func_q))
        bpfa_pkg::FUNC_ALLOC: begin
          if (free_q == '0) begin
            finish = out_free;
          end else if (&masked) begin
            hint_d  = hint_q + WADDR_W'(1);
            rd_en   = 1'b1;
            rd_addr = hint_d;
          end else if (out_free) begin
            finish      = 1'b1;
            wr_en       = 1'b1;
            wr_addr     = hint_q;
            wr_data     = rd_data | (WW'(1) << lo);
            free_d      = free_q - CNT_W'(1);
            used_d      = (used_q != CNT_W'(PAGES)) ? used_q + CNT_W'(1) : used_q;
            out_page_d  = idx_got[bpfa_pkg::PAGE_W-1:0];
            out_found_d = 1'b1;
          end
        end
        bpfa_pkg::FUNC_RESERVE: begin
          if (out_free) begin
            finish = 1'b1;
            if (pvalid_q && !rd_data[bit_q]) begin
              wr_en   = 1'b1;
              wr_addr = word_q;
              wr_data = rd_data | (WW'(1) << bit_q);
              free_d  = free_q - CNT_W'(1);
              rsv_d   = rsv_q + CNT_W'(1);
            end
          end
        end
        bpfa_pkg::FUNC_FREE: begin
          if (out_free) begin
            finish = 1'b1;
            if (pvalid_q && rd_data[bit_q]) begin
              wr_en   = 1'b1;
              wr_addr = word_q;
              wr_data = rd_data & ~(WW'(1) << bit_q);
              free_d  = free_q + CNT_W'(1);
              rsv_d   = (rsv_q != '0) ? rsv_q - CNT_W'(1) : rsv_q;
              if (word_q < hint_q) begin
                hint_d = word_q;
              end
            end
          end
        end
        default: begin
          finish = out_free;
        end
      endcase
      if (finish) begin
        state_d = ST_IDLE;
      end
    end
  end

  assign out_valid_d = finish || (out_valid_q && !rsp_o.ready);
  assign free_x      = CX_W'(free_d);
  assign used_x      = CX_W'(used_d);
  assign rsv_x       = CX_W'(rsv_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hint_q      <= '0;
      free_q      <= CNT_W'(PAGES - 1);
      used_q      <= '0;
      rsv_q       <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      free_q      <= free_d;
      used_q      <= used_d;
      rsv_q       <= rsv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    word_q   <= word_d;
    bit_q    <= bit_d;
    pvalid_q <= pvalid_d;
    if (finish) begin
      out_page_q  <= out_page_d;
      out_found_q <= out_found_d;
      out_free_q  <= free_x[bpfa_pkg::CNT_OUT_W-1:0];
      out_used_q  <= used_x[bpfa_pkg::CNT_OUT_W-1:0];
      out_rsv_q   <= rsv_x[bpfa_pkg::CNT_OUT_W-1:0];
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.allocated_page = out_page_q;
  assign rsp_o.found          = out_found_q;
  assign rsp_o.free_pages     = out_free_q;
  assign rsp_o.used_pages     = out_used_q;
  assign rsp_o.reserved_pages = out_rsv_q;

endmodule

FILE: src/bpfa_checker.sv
module bpfa_checker #(
  parameter int PAGES = bpfa_pkg::PAGES_DEFAULT
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [bpfa_pkg::PAGE_W-1:0]    rsp_page_i,
  input logic                           rsp_found_i,
  input logic [bpfa_pkg::CNT_OUT_W-1:0] rsp_free_i,
  input logic [bpfa_pkg::CNT_OUT_W-1:0] rsp_rsv_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_page_i)
      && $stable(rsp_found_i) && $stable(rsp_free_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  a_page_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_page_i == '0)
    else $error("page reported without a successful allocate");

  a_counts_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (PAGES > 4096)
      || (32'(rsp_free_i) + 32'(rsp_rsv_i) <= PAGES))
    else $error("free plus reserved exceeds page count");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker #(.PAGES(PAGES)) u_bpfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_page_i  (rsp_o.allocated_page),
  .rsp_found_i (rsp_o.found),
  .rsp_free_i  (rsp_o.free_pages),
  .rsp_rsv_i   (rsp_o.reserved_pages)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import bpfa_pkg::*;

  localparam int PAGES = PAGES_DEFAULT;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0]    page;
    logic                 found;
    logic [CNT_OUT_W-1:0] free_pages;
    logic [CNT_OUT_W-1:0] used_pages;
    logic [CNT_OUT_W-1:0] reserved_pages;
  } alloc_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpfa_req_if req_if();
  bpfa_rsp_if rsp_if();

  bitmap_page_frame_allocator_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  bit         page_taken [PAGES];
  int         n_free;
  int         n_used;
  int         n_reserved;
  alloc_rsp_t expected_rsps [$];
  int         error_count = 0;
  int         gap_max = 5;

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic int lowest_free_page();
    for (int i = 0; i < PAGES; i++) begin
      if (!page_taken[i]) return i;
    end
    return -1;
  endfunction

  function automatic alloc_rsp_t apply_request(input logic [1:0] fn,
                                               input logic [PAGE_W-1:0] pg);
    alloc_rsp_t r;
    int p;
    r = '0;
    case (fn)
      FUNC_ALLOC: begin
        p = lowest_free_page();
        if (p >= 0) begin
          page_taken[p] = 1'b1;
          n_free--;
          if (n_used < PAGES) n_used++;
          r.page  = PAGE_W'(p);
          r.found = 1'b1;
        end
      end
      FUNC_RESERVE: begin
        if (!page_taken[pg]) begin
          page_taken[pg] = 1'b1;
          n_free--;
          n_reserved++;
        end
      end
      FUNC_FREE: begin
        if (page_taken[pg]) begin
          page_taken[pg] = 1'b0;
          n_free++;
          if (n_reserved > 0) n_reserved--;
        end
      end
      default: ;
    endcase
    r.free_pages     = CNT_OUT_W'(n_free);
    r.used_pages     = CNT_OUT_W'(n_used);
    r.reserved_pages = CNT_OUT_W'(n_reserved);
    return r;
  endfunction

  task automatic send_req(input logic [1:0] fn, input logic [PAGE_W-1:0] pg);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= fn;
    req_if.page_index <= pg;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsps.push_back(apply_request(fn, pg));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(0, 1) == 0) return PAGE_W'($urandom_range(0, PAGES - 1));
    return PAGE_W'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    send_req(FUNC_ALLOC, 12'h000);
    send_req(FUNC_ALLOC, 12'hfff);
    send_req(FUNC_RESERVE, 12'h000);
    send_req(FUNC_RESERVE, 12'h003);
    send_req(FUNC_ALLOC, 12'h000);
    send_req(FUNC_FREE, 12'h003);
    send_req(FUNC_ALLOC, 12'h555);
    send_req(FUNC_RESERVE, 12'hfff);
    send_req(FUNC_RESERVE, 12'hfff);
    send_req(FUNC_FREE, 12'hfff);
    send_req(FUNC_FREE, 12'hfff);
    send_req(FUNC_FREE, 12'h000);
    send_req(FUNC_FREE, 12'h001);
    send_req(FUNC_FREE, 12'h002);
    send_req(FUNC_UNUSED, 12'hfff);
    send_req(FUNC_UNUSED, 12'h000);
    send_req(FUNC_RESERVE, 12'h555);
    send_req(FUNC_RESERVE, 12'haaa);
    send_req(FUNC_FREE, 12'h555);
    send_req(FUNC_FREE, 12'haaa);
    send_req(FUNC_ALLOC, 12'haaa);
    send_req(FUNC_RESERVE, 12'h03f);
    send_req(FUNC_RESERVE, 12'h040);
    send_req(FUNC_ALLOC, 12'h000);
    send_req(FUNC_ALLOC, 12'h000);
  endtask

  task automatic test_random(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      gap_max = ((i / 100) % 3 == 2) ? 0 : 5;
      sel = $urandom_range(0, 99);
      if (sel < 40)      send_req(FUNC_ALLOC, PAGE_W'($urandom));
      else if (sel < 65) send_req(FUNC_RESERVE, pick_page());
      else if (sel < 95) send_req(FUNC_FREE, pick_page());
      else               send_req(FUNC_UNUSED, PAGE_W'($urandom));
    end
    gap_max = 5;
  endtask

  task automatic test_release_all();
    for (int p = 0; p < PAGES; p++) begin
      if (page_taken[p]) send_req(FUNC_FREE, PAGE_W'(p));
    end
    send_req(FUNC_ALLOC, 12'hfff);
  endtask

  initial begin : responder
    alloc_rsp_t got;
    alloc_rsp_t want;
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, gap_max);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      got.page           = rsp_if.allocated_page;
      got.found          = rsp_if.found;
      got.free_pages     = rsp_if.free_pages;
      got.used_pages     = rsp_if.used_pages;
      got.reserved_pages = rsp_if.reserved_pages;
      if (expected_rsps.size() == 0) begin
        report($sformatf("result transfer with nothing outstanding: page %0d", got.page));
      end else begin
        want = expected_rsps.pop_front();
        if (got.page !== want.page)
          report($sformatf("allocated_page got %0d exp %0d", got.page, want.page));
        if (got.found !== want.found)
          report($sformatf("found got %0b exp %0b", got.found, want.found));
        if (got.free_pages !== want.free_pages)
          report($sformatf("free_pages got %0d exp %0d", got.free_pages, want.free_pages));
        if (got.used_pages !== want.used_pages)
          report($sformatf("used_pages got %0d exp %0d", got.used_pages, want.used_pages));
        if (got.reserved_pages !== want.reserved_pages)
          report($sformatf("reserved_pages got %0d exp %0d",
                           got.reserved_pages, want.reserved_pages));
      end
    end
  end

  initial begin : watchdog
    #30ms;
    $display("bitmap_page_frame_allocator_top regression: fail");
    $finish;
  end

  initial begin : main
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.func       <= FUNC_ALLOC;
    req_if.page_index <= '0;
    for (int i = 0; i < PAGES; i++) page_taken[i] = 1'b0;
    page_taken[0] = 1'b1;
    n_free     = PAGES - 1;
    n_used     = 0;
    n_reserved = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(700);
    wait_drained();
    repeat (3) @(posedge clk_i);
    test_release_all();
    test_random(300);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("bitmap_page_frame_allocator_top regression: pass");
    end else begin
      $display("bitmap_page_frame_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: bitmap_page_frame_allocator_top.f
src/bpfa_pkg.sv
src/bpfa_if.sv
src/bpfa_map.sv
src/bitmap_page_frame_allocator_top.sv
src/bpfa_checker.sv
tb/tb.sv
